[hw/rtl/tablet_report_decoder_core_assert.svh]
// Assertion macros for the tablet report decoder checker.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef TABLET_REPORT_DECODER_CORE_ASSERT_SVH
`define TABLET_REPORT_DECODER_CORE_ASSERT_SVH

// Same-cycle implication.
`define TRD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/trd_pkg.sv]
// Shared types, codes and scaling constants for the tablet report decoder.
// No dependencies; imported by every RTL module of the block.
package trd_pkg;

  // Report layouts selected by the configuration register
  typedef enum logic [2:0] {
    MdlDefault  = 3'd0,
    MdlSmallPad = 3'd1,
    MdlPenPal   = 3'd2,
    MdlArtIv    = 3'd3,
    MdlArtWide  = 3'd4
  } trd_model_e;

  // Report kinds (byte 0)
  localparam logic [7:0] KindButtons = 8'h01;
  localparam logic [7:0] KindPen     = 8'h02;
  localparam logic [7:0] KindPadKeys = 8'h0c;

  // Slider markers and limits
  localparam logic [7:0] MarkLeft    = 8'h55;
  localparam logic [7:0] MarkRight   = 8'haa;
  localparam logic [3:0] SliderKeyNib = 4'ha;
  localparam logic [7:0] SliderMax   = 8'h3f;
  localparam logic [7:0] SliderReset = 8'hfb;  // -5
  localparam logic [7:0] PressKeyThr = 8'd68;

  // Key bit positions
  localparam int unsigned KeyLeft   = 0;
  localparam int unsigned KeyRight  = 1;
  localparam int unsigned KeyMiddle = 2;
  localparam int unsigned KeyPad0   = 3;

  localparam int unsigned KeyW   = 11;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned InUserW  = 8;
  localparam int unsigned OutDataW = 88;
  localparam int unsigned OutUserW = 4;
  localparam int unsigned TrdQueueDepth = 2;

  // Coordinate scaling: pos = raw*65535/max, saturated
  typedef enum logic {
    ScaleStd   = 1'b0,
    ScaleLarge = 1'b1
  } trd_scale_e;

  localparam int unsigned MaxW   = 15;
  localparam int unsigned RecipW = 20;

  localparam logic [MaxW-1:0] MaxStdX   = 15'h27de;
  localparam logic [MaxW-1:0] MaxStdY   = 15'h1cfe;
  localparam logic [MaxW-1:0] MaxLargeX = 15'h5750;
  localparam logic [MaxW-1:0] MaxLargeY = 15'h3692;

  // floor(65535 * 2^16 / max)
  localparam logic [63:0] ScaleNum = 64'd4294901760;
  localparam logic [RecipW-1:0] RecipStdX   = RecipW'(ScaleNum / 64'h27de);
  localparam logic [RecipW-1:0] RecipStdY   = RecipW'(ScaleNum / 64'h1cfe);
  localparam logic [RecipW-1:0] RecipLargeX = RecipW'(ScaleNum / 64'h5750);
  localparam logic [RecipW-1:0] RecipLargeY = RecipW'(ScaleNum / 64'h3692);

  function automatic logic [MaxW-1:0] scale_max(trd_scale_e sel, logic axis_y);
    logic [MaxW-1:0] m;
    case (sel)
      ScaleLarge: m = axis_y ? MaxLargeY : MaxLargeX;
      default:    m = axis_y ? MaxStdY : MaxStdX;
    endcase
    return m;
  endfunction

  function automatic logic [RecipW-1:0] scale_recip(trd_scale_e sel, logic axis_y);
    logic [RecipW-1:0] r;
    case (sel)
      ScaleLarge: r = axis_y ? RecipLargeY : RecipLargeX;
      default:    r = axis_y ? RecipStdY : RecipStdX;
    endcase
    return r;
  endfunction

  // Classified item handed from front to back
  typedef struct packed {
    trd_scale_e       scale_sel;
    logic             pos_valid;
    logic [1:0][15:0] raw;          // [0] x, [1] y
    logic             tilt_valid;
    logic [5:0]       tilt_x;
    logic [7:0]       tilt_y;
    logic             pressure_valid;
    logic [15:0]      pen_pressure;
    logic [KeyW-1:0]  key_mask;
    logic [KeyW-1:0]  key_levels;
    logic             wheel_valid;
    logic [3:0]       wheel_delta;
  } trd_entry_t;

  typedef struct packed {
    logic            pos_valid;
    logic [15:0]     pos_x;
    logic [15:0]     pos_y;
    logic            tilt_valid;
    logic [5:0]      tilt_x;
    logic [7:0]      tilt_y;
    logic            pressure_valid;
    logic [15:0]     pen_pressure;
    logic [KeyW-1:0] key_mask;
    logic [KeyW-1:0] key_levels;
    logic            wheel_valid;
    logic [3:0]      wheel_delta;
  } trd_result_t;

endpackage

[hw/rtl/tablet_report_decoder_core.sv]
// An accepted input beat passes queue write, scale estimate, scale multiply
//   and output register; the two multiply stages per axis set the depth.
// Throughput: 1 beat per cycle unless m_axis_tready stalls the output.
// Reset (rst_ni low, async): model returns to default, slider position to -5,
//   queue and pipeline empty.
module tablet_report_decoder_core import trd_pkg::*; #(
  parameter int unsigned QueueDepth = TrdQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration: tablet_model
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_data_i,
  // report input
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] status_bits, [15:8] field_byte2, [23:16] field_byte3,
  // [31:24] field_byte4, [39:32] field_byte5, [47:40] field_byte6,
  // [55:48] field_byte7, [63:56] field_byte8
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [7:0] report_kind
  input  logic [InUserW-1:0]  s_axis_tuser,
  // decoded result
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [15:0] pos_x, [31:16] pos_y, [37:32] tilt_x, [45:38] tilt_y,
  // [61:46] pen_pressure, [72:62] key_update_mask, [83:73] key_levels,
  // [87:84] wheel_delta
  output logic [OutDataW-1:0] m_axis_tdata,
  // [0] position_valid, [1] tilt_valid, [2] pressure_valid, [3] wheel_valid
  output logic [OutUserW-1:0] m_axis_tuser
);

  // Front classifies each beat in the accept cycle and updates slider state;
  // back does the per-axis scaling and holds the result until taken.
  trd_entry_t  push_data, pop_data;
  trd_result_t res;
  logic        push, q_full, q_valid, pop;

  assign cfg_ready_o = 1'b1;

  trd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .kind_i      (s_axis_tuser),
    .data_i      (s_axis_tdata),
    .q_full_i    (q_full),
    .push_o      (push),
    .entry_o     (push_data)
  );

  // Decouples the front from output backpressure
  trd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_data),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (pop_data)
  );

  trd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  assign m_axis_tdata = {res.wheel_delta, res.key_levels, res.key_mask, res.pen_pressure,
                         res.tilt_y, res.tilt_x, res.pos_y, res.pos_x};
  assign m_axis_tuser = {res.wheel_valid, res.pressure_valid, res.tilt_valid, res.pos_valid};

endmodule

[hw/rtl/trd_front.sv]
// Front end: model register, report classification, key/pressure/tilt
// decode and slider state. Depends on trd_pkg.
module trd_front import trd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [2:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [InUserW-1:0] kind_i,
  input  logic [InDataW-1:0] data_i,
  input  logic               q_full_i,
  output logic               push_o,
  output trd_entry_t         entry_o
);

  logic [2:0]       model_q;
  logic [7:0]       last_q, last_d;
  trd_model_e       model;
  logic [7:0]       s, b2, b3, b4, b5, b6, b7, b8;
  logic [15:0]      be_x, be_y, le_x, le_y, be_p;
  logic [1:0]       side_en;
  logic [1:0][7:0]  side_d;
  logic signed [8:0] diff;
  trd_entry_t       e;

  assign {b8, b7, b6, b5, b4, b3, b2, s} = data_i;
  assign be_x = {b2, b3};
  assign be_y = {b4, b5};
  assign le_x = {b3, b2};
  assign le_y = {b5, b4};
  assign be_p = {b6, b7};

  assign model = (model_q > 3'd4) ? MdlDefault : trd_model_e'(model_q);

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    e       = '0;
    side_en = '0;
    side_d  = '0;
    diff    = '0;
    last_d  = last_q;
    case (model)
      MdlDefault, MdlSmallPad: begin
        if (kind_i == KindButtons) begin
          side_en[0] = (s == MarkLeft);
          side_d[0]  = b2;
          side_en[1] = (b3 == MarkRight);
          side_d[1]  = b4;
        end else if (kind_i == KindPen) begin
          if (s[7:4] != 4'h0) begin
            e.pos_valid      = 1'b1;
            e.raw            = {be_y, be_x};
            e.tilt_valid     = 1'b1;
            e.tilt_x         = b7[5:0];
            e.tilt_y         = b8;
            e.pressure_valid = 1'b1;
            e.pen_pressure   = be_p >> 6;
          end
          e.key_mask[KeyLeft]   = 1'b1;
          e.key_levels[KeyLeft] = (model == MdlDefault) ? s[0] : (b6 > PressKeyThr);
          e.key_mask[KeyRight]   = 1'b1;
          e.key_levels[KeyRight] = s[1];
          e.key_mask[KeyPad0]    = 1'b1;
          e.key_levels[KeyPad0]  = s[5];
        end
      end
      MdlPenPal: begin
        if (kind_i == KindPen) begin
          if (s[7:5] == 3'b111) begin
            if (s[0]) begin
              e.pressure_valid = 1'b1;
              e.pen_pressure   = be_p >> 6;
            end
            if (s[2]) begin
              e.key_mask[KeyRight]   = 1'b1;
              e.key_levels[KeyRight] = s[1];
            end
            e.pos_valid           = 1'b1;
            e.raw                 = {be_y, be_x};
            e.key_mask[KeyPad0]   = 1'b1;
            e.key_levels[KeyPad0] = (b6 != 8'h00);
          end
        end else if (kind_i == KindPadKeys) begin
          e.key_mask[KeyPad0+3:KeyPad0]   = 4'hf;
          e.key_levels[KeyPad0+3:KeyPad0] = b3[3:0];
        end
      end
      MdlArtIv, MdlArtWide: begin
        e.scale_sel = ScaleLarge;
        if (kind_i == KindButtons) begin
          e.pos_valid = 1'b1;
          e.raw       = {le_y, le_x};
          e.key_mask[KeyPad0:KeyLeft]   = 4'hf;
          e.key_levels[KeyPad0:KeyLeft] = s[3:0];
          if (model == MdlArtWide) begin
            e.pressure_valid = 1'b1;
            e.pen_pressure   = {b7, b6};
          end
        end else if (kind_i == KindPen && model == MdlArtIv) begin
          e.pos_valid = 1'b1;
          e.raw       = {be_y, be_x};
          if (s[0]) begin
            e.pressure_valid = 1'b1;
            e.pen_pressure   = be_p >> 6;
          end
        end else if (kind_i == KindPadKeys) begin
          if (model == MdlArtIv) begin
            e.key_mask[KeyW-1:KeyPad0+1]   = 7'h7f;
            e.key_levels[KeyW-1:KeyPad0+1] = b3[6:0];
          end else begin
            e.key_mask[KeyW-1:KeyPad0]   = 8'hff;
            e.key_levels[KeyW-1:KeyPad0] = b3;
          end
        end
      end
      default: ;
    endcase

    // Sliders, left then right; right sees the left update
    for (int sd = 0; sd < 2; sd++) begin
      if (side_en[sd]) begin
        if (side_d[sd][7:4] == SliderKeyNib) begin
          for (int k = 0; k < 3; k++) begin
            e.key_mask[KeyPad0 + 1 + 4*sd + k]   = 1'b1;
            e.key_levels[KeyPad0 + 1 + 4*sd + k] = side_d[sd][k+1];
          end
        end else if (side_d[sd] <= SliderMax) begin
          diff = $signed({1'b0, side_d[sd]}) - $signed({last_d[7], last_d});
          if (diff > -9'sd4 && diff < 9'sd4) begin
            e.wheel_delta = e.wheel_delta + diff[3:0];
            e.wheel_valid = 1'b1;
          end
          last_d = side_d[sd];
        end
      end
    end
  end

  assign entry_o = e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q <= MdlDefault;
      last_q  <= SliderReset;
    end else begin
      if (cfg_valid_i) model_q <= cfg_data_i;
      if (push_o)      last_q  <= last_d;
    end
  end

endmodule

[hw/rtl/trd_queue.sv]
// Small FIFO between front and back ends of the tablet report decoder.
// Depends on trd_pkg for the entry type.
module trd_queue import trd_pkg::*; #(
  parameter int unsigned Depth = TrdQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  trd_entry_t wdata_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output trd_entry_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  trd_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      if (do_pop)  rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

[hw/rtl/trd_back.sv]
// Back end: three-stage position scaling pipeline with output register.
// Reciprocal multiply, remainder correction, saturation. Depends on trd_pkg.
module trd_back import trd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  trd_entry_t  q_data_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output trd_result_t out_data_o
);

  // stage 1: quotient estimate
  logic                   v1_q;
  trd_entry_t             e1_q;
  logic [1:0]             sat1_q;
  logic [1:0][15:0]       q1_q;
  // stage 2: quotient times divisor
  logic                   v2_q;
  trd_entry_t             e2_q;
  logic [1:0]             sat2_q;
  logic [1:0][15:0]       q2_q;
  logic [1:0][30:0]       t2_q;
  // output
  logic                   vo_q;
  trd_result_t            res_q, res_d;

  logic                   en1, en2, eno;
  logic [1:0]             sat1_d;
  logic [1:0][15:0]       q1_d;
  logic [1:0][30:0]       t2_d;
  logic [1:0][15:0]       pos;
  logic [MaxW+RecipW-1:0] prod1 [2];
  logic [30:0]            num3 [2];
  logic [30:0]            rem3 [2];

  assign eno   = !vo_q || out_ready_i;
  assign en2   = !v2_q || eno;
  assign en1   = !v1_q || en2;
  assign pop_o = en1 && q_valid_i;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      sat1_d[c] = q_data_i.raw[c] >= {1'b0, scale_max(q_data_i.scale_sel, c[0])};
      prod1[c]  = q_data_i.raw[c][MaxW-1:0] * scale_recip(q_data_i.scale_sel, c[0]);
      q1_d[c]   = prod1[c][31:16];
      t2_d[c]   = q1_q[c] * scale_max(e1_q.scale_sel, c[0]);
      num3[c]   = {e2_q.raw[c][MaxW-1:0], 16'h0000} - {16'h0000, e2_q.raw[c][MaxW-1:0]};
      rem3[c]   = num3[c] - t2_q[c];
      if (sat2_q[c]) begin
        pos[c] = 16'hffff;
      end else if (rem3[c] >= {16'h0000, scale_max(e2_q.scale_sel, c[0])}) begin
        pos[c] = q2_q[c] + 16'd1;
      end else begin
        pos[c] = q2_q[c];
      end
    end
  end

  always_comb begin
    res_d.pos_valid      = e2_q.pos_valid;
    res_d.pos_x          = pos[0];
    res_d.pos_y          = pos[1];
    res_d.tilt_valid     = e2_q.tilt_valid;
    res_d.tilt_x         = e2_q.tilt_x;
    res_d.tilt_y         = e2_q.tilt_y;
    res_d.pressure_valid = e2_q.pressure_valid;
    res_d.pen_pressure   = e2_q.pen_pressure;
    res_d.key_mask       = e2_q.key_mask;
    res_d.key_levels     = e2_q.key_levels;
    res_d.wheel_valid    = e2_q.wheel_valid;
    res_d.wheel_delta    = e2_q.wheel_delta;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      e1_q   <= q_data_i;
      sat1_q <= sat1_d;
      q1_q   <= q1_d;
    end
    if (en2 && v1_q) begin
      e2_q   <= e1_q;
      sat2_q <= sat1_q;
      q2_q   <= q1_q;
      t2_q   <= t2_d;
    end
    if (eno && v2_q) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= q_valid_i;
      if (en2) v2_q <= v1_q;
      if (eno) vo_q <= v2_q;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = res_q;

endmodule

[hw/rtl/trd_checker.sv]
// Port-level checks for tablet_report_decoder_core, bound to the top level.
// Depends on trd_pkg and tablet_report_decoder_core_assert.svh.
`include "tablet_report_decoder_core_assert.svh"

module trd_port_checker import trd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [OutUserW-1:0] m_axis_tuser
);

  logic                         stall;
  logic                         wheel_off;
  logic                         tilt_on;
  logic [OutUserW+OutDataW-1:0] beat;
  logic [KeyW-1:0]              mask;
  logic [KeyW-1:0]              levels;
  logic [3:0]                   wdelta;

  assign stall     = m_axis_tvalid && !m_axis_tready;
  assign wheel_off = m_axis_tvalid && !m_axis_tuser[3];
  assign tilt_on   = m_axis_tvalid && m_axis_tuser[1];
  assign beat      = {m_axis_tuser, m_axis_tdata};
  assign mask      = m_axis_tdata[72:62];
  assign levels    = m_axis_tdata[83:73];
  assign wdelta    = m_axis_tdata[87:84];

  // stalled result beat must hold
  `TRD_ASSERT_NEXT(a_out_hold, stall, m_axis_tvalid && $stable(beat), "held beat changed")

  // levels only for reported keys
  `TRD_ASSERT_IMPLY(a_levels_in_mask, m_axis_tvalid, (levels & ~mask) == '0, "level outside mask")

  // no wheel report means zero delta
  `TRD_ASSERT_IMPLY(a_wheel_zero, wheel_off, wdelta == 4'h0, "wheel delta without wheel report")

  // tilt comes only with a pen position
  `TRD_ASSERT_IMPLY(a_tilt_pos, tilt_on, m_axis_tuser[0], "tilt reported without position")

endmodule

bind tablet_report_decoder_core trd_port_checker u_trd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/sv/trd_checker.sv]
// Scoreboard for the tablet report decoder: predicts each result from the
// accepted report beats and compares the result beats field by field.
// Depends on trd_pkg for the result layout, report kinds and constants.
module trd_checker import trd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [2:0]          cfg_data_i,
  input  logic                rpt_valid_i,
  input  logic                rpt_ready_i,
  input  logic [InDataW-1:0]  rpt_data_i,
  input  logic [InUserW-1:0]  rpt_user_i,
  input  logic                res_valid_i,
  input  logic                res_ready_i,
  input  logic [OutDataW-1:0] res_data_i,
  input  logic [OutUserW-1:0] res_user_i,
  output int                  errors_o,
  output int                  pending_o
);

  logic [2:0]      cur_model = MdlDefault;
  int              slider_pos = -5;
  logic [KeyW-1:0] keys_seen;
  logic [KeyW-1:0] keys_down;
  int              wheel_sum;
  logic            wheel_hit;
  trd_result_t     decoded_q[$];

  function automatic void set_key(int unsigned idx, logic pressed);
    keys_seen[idx] = 1'b1;
    keys_down[idx] = pressed;
  endfunction

  // side: 0 for the left group, 4 for the right group of pad keys
  function automatic void take_slider(int unsigned side, logic [7:0] d);
    int diff;
    if (d[7:4] == SliderKeyNib) begin
      set_key(KeyPad0 + side + 1, d[1]);
      set_key(KeyPad0 + side + 2, d[2]);
      set_key(KeyPad0 + side + 3, d[3]);
    end else if (d <= SliderMax) begin
      diff = int'(d) - slider_pos;
      if (diff > -4 && diff < 4) begin
        wheel_sum += diff;
        wheel_hit = 1'b1;
      end
      slider_pos = int'(d);
    end
  endfunction

  function automatic logic [15:0] scale_pos(logic [15:0] raw, int unsigned maxv);
    longint q;
    q = (longint'(raw) * 65535) / maxv;
    return (q > 65535) ? 16'hffff : 16'(q);
  endfunction

  function automatic trd_result_t decode_report(logic [2:0] mdl_raw, logic [7:0] kind,
                                               logic [InDataW-1:0] data);
    trd_result_t     r;
    logic [8:1][7:0] rb;
    logic [2:0]      mdl;
    logic [15:0]     be_x, be_y, le_x, le_y, be_p;
    r = '0;
    rb = data;
    keys_seen = '0;
    keys_down = '0;
    wheel_sum = 0;
    wheel_hit = 1'b0;
    mdl  = (mdl_raw > MdlArtWide) ? MdlDefault : mdl_raw;
    be_x = {rb[2], rb[3]};
    be_y = {rb[4], rb[5]};
    le_x = {rb[3], rb[2]};
    le_y = {rb[5], rb[4]};
    be_p = {rb[6], rb[7]};

    if (mdl == MdlDefault || mdl == MdlSmallPad) begin
      if (kind == KindButtons) begin
        if (rb[1] == MarkLeft) take_slider(0, rb[2]);
        if (rb[3] == MarkRight) take_slider(4, rb[4]);
      end else if (kind == KindPen) begin
        if (rb[1][7:4] != 4'h0) begin
          r.pos_valid      = 1'b1;
          r.pos_x          = scale_pos(be_x, MaxStdX);
          r.pos_y          = scale_pos(be_y, MaxStdY);
          r.tilt_valid     = 1'b1;
          r.tilt_x         = rb[7][5:0];
          r.tilt_y         = rb[8];
          r.pressure_valid = 1'b1;
          r.pen_pressure   = be_p >> 6;
        end
        if (mdl == MdlDefault) set_key(KeyLeft, rb[1][0]);
        else set_key(KeyLeft, rb[6] > PressKeyThr);
        set_key(KeyRight, rb[1][1]);
        set_key(KeyPad0, rb[1][5]);
      end
    end else if (mdl == MdlPenPal) begin
      if (kind == KindPen) begin
        if (rb[1][7:5] == 3'b111) begin
          if (rb[1][0]) begin
            r.pressure_valid = 1'b1;
            r.pen_pressure   = be_p >> 6;
          end
          if (rb[1][2]) set_key(KeyRight, rb[1][1]);
          r.pos_valid = 1'b1;
          r.pos_x     = scale_pos(be_x, MaxStdX);
          r.pos_y     = scale_pos(be_y, MaxStdY);
          set_key(KeyPad0, rb[6] != 8'h00);
        end
      end else if (kind == KindPadKeys) begin
        for (int i = 0; i < 4; i++) set_key(KeyPad0 + i, rb[3][i]);
      end
    end else begin
      if (kind == KindButtons) begin
        r.pos_valid = 1'b1;
        r.pos_x     = scale_pos(le_x, MaxLargeX);
        r.pos_y     = scale_pos(le_y, MaxLargeY);
        set_key(KeyLeft, rb[1][0]);
        set_key(KeyRight, rb[1][1]);
        set_key(KeyMiddle, rb[1][2]);
        set_key(KeyPad0, rb[1][3]);
        if (mdl == MdlArtWide) begin
          r.pressure_valid = 1'b1;
          r.pen_pressure   = {rb[7], rb[6]};
        end
      end else if (kind == KindPen && mdl == MdlArtIv) begin
        r.pos_valid = 1'b1;
        r.pos_x     = scale_pos(be_x, MaxLargeX);
        r.pos_y     = scale_pos(be_y, MaxLargeY);
        if (rb[1][0]) begin
          r.pressure_valid = 1'b1;
          r.pen_pressure   = be_p >> 6;
        end
      end else if (kind == KindPadKeys) begin
        if (mdl == MdlArtIv) begin
          for (int i = 0; i < 7; i++) set_key(KeyPad0 + 1 + i, rb[3][i]);
        end else begin
          for (int i = 0; i < 8; i++) set_key(KeyPad0 + i, rb[3][i]);
        end
      end
    end

    r.key_mask    = keys_seen;
    r.key_levels  = keys_down;
    r.wheel_valid = wheel_hit;
    r.wheel_delta = wheel_hit ? 4'(wheel_sum) : 4'h0;
    return r;
  endfunction

  function automatic void check_field(string name, longint expv, longint actv);
    if (expv != actv) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expv, actv);
      errors_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    trd_result_t want;
    if (!rst_ni) begin
      cur_model  = MdlDefault;
      slider_pos = int'($signed(SliderReset));
      decoded_q.delete();
    end else begin
      // result first: it always belongs to an older report
      if (res_valid_i && res_ready_i) begin
        if (decoded_q.size() == 0) begin
          $error("result beat with no report waiting");
          errors_o++;
        end else begin
          want = decoded_q.pop_front();
          check_field("position_valid", want.pos_valid, res_user_i[0]);
          check_field("tilt_valid", want.tilt_valid, res_user_i[1]);
          check_field("pressure_valid", want.pressure_valid, res_user_i[2]);
          check_field("wheel_valid", want.wheel_valid, res_user_i[3]);
          check_field("pos_x", want.pos_x, res_data_i[15:0]);
          check_field("pos_y", want.pos_y, res_data_i[31:16]);
          check_field("tilt_x", want.tilt_x, res_data_i[37:32]);
          check_field("tilt_y", want.tilt_y, res_data_i[45:38]);
          check_field("pen_pressure", want.pen_pressure, res_data_i[61:46]);
          check_field("key_update_mask", want.key_mask, res_data_i[72:62]);
          check_field("key_levels", want.key_levels, res_data_i[83:73]);
          check_field("wheel_delta", want.wheel_delta, res_data_i[87:84]);
        end
      end
      if (rpt_valid_i && rpt_ready_i)
        decoded_q.push_back(decode_report(cur_model, rpt_user_i, rpt_data_i));
      // a model write takes effect from the next beat on
      if (cfg_valid_i && cfg_ready_i) cur_model = cfg_data_i;
    end
    pending_o = decoded_q.size();
  end

endmodule

[tb/sv/tb_top.sv]
// Top of the tablet report decoder testbench: clock, reset, report and
// model stimulus, stall control on both sides, and the verdict.
// Depends on trd_pkg, tablet_report_decoder_core and trd_checker.
module tb_top;
  import trd_pkg::*;

  // Model codes beyond the defined layouts; the block decodes them as default
  localparam logic [2:0] MdlSpareLo = 3'd5;
  localparam logic [2:0] MdlSpareHi = 3'd7;
  // A report kind that no layout knows
  localparam logic [7:0] KindUnknown = 8'h77;
  // Receiver hold-off long enough to back up the whole pipeline
  localparam int HoldCycles = 300;
  localparam int RandPhases = 8;
  localparam int PhaseItems = 88;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [2:0]          cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [InUserW-1:0]  s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;

  int   fail_count;
  int   pending_count;
  int   reports_sent = 0;
  int   models_set = 0;
  logic quiet = 1'b0;      // no idling on either side
  logic hold_req = 1'b0;   // ask the receiver for one long hold-off

  always #5 clk_i = ~clk_i;

  tablet_report_decoder_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  trd_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_i(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .rpt_valid_i(s_axis_tvalid),
    .rpt_ready_i(s_axis_tready),
    .rpt_data_i (s_axis_tdata),
    .rpt_user_i (s_axis_tuser),
    .res_valid_i(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_data_i (m_axis_tdata),
    .res_user_i (m_axis_tuser),
    .errors_o   (fail_count),
    .pending_o  (pending_count)
  );

  // Offer one report beat; called at a falling edge, returns at the falling
  // edge after the beat is taken with tvalid still high.
  task automatic send_report(logic [7:0] kind, logic [7:0] s, logic [7:0] b2,
                             logic [7:0] b3, logic [7:0] b4, logic [7:0] b5,
                             logic [7:0] b6, logic [7:0] b7, logic [7:0] b8);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {b8, b7, b6, b5, b4, b3, b2, s};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    reports_sent++;
  endtask

  task automatic idle_sender(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Every report yields exactly one result, so an empty scoreboard means
  // the block is idle.
  task automatic wait_drained();
    while (pending_count != 0) @(negedge clk_i);
  endtask

  task automatic set_model(logic [2:0] mdl);
    idle_sender(1);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mdl;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    models_set++;
  endtask

  // Slider bytes: often small positions so deltas land under four, plus
  // key nibbles, the full position range and raw noise.
  function automatic logic [7:0] slider_byte();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return 8'($urandom_range(0, 7));
    if (pick < 6) return 8'($urandom_range(0, SliderMax));
    if (pick < 8) return {SliderKeyNib, 4'($urandom)};
    return 8'($urandom);
  endfunction

  // One random report: well-formed kinds with random content most of the
  // time, full noise otherwise.
  task automatic send_random();
    logic [8:1][7:0] rb;
    logic [7:0]      kind;
    int              pick;
    for (int i = 1; i <= 8; i++) rb[i] = 8'($urandom);
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      kind = 8'($urandom);
    end else begin
      case ($urandom_range(0, 2))
        0:       kind = KindButtons;
        1:       kind = KindPen;
        default: kind = KindPadKeys;
      endcase
      if (kind == KindButtons) begin
        if ($urandom_range(0, 4) != 0) rb[1] = MarkLeft;
        if ($urandom_range(0, 4) != 0) rb[3] = MarkRight;
        rb[2] = slider_byte();
        rb[4] = slider_byte();
      end else if (kind == KindPen) begin
        if ($urandom_range(0, 3) != 0) rb[1][7:5] = 3'b111;
        // pressure around the small-pad click threshold
        if ($urandom_range(0, 3) == 0) rb[6] = 8'($urandom_range(PressKeyThr - 2,
                                                                 PressKeyThr + 2));
      end
    end
    send_report(kind, rb[1], rb[2], rb[3], rb[4], rb[5], rb[6], rb[7], rb[8]);
  endtask

  // Receiver: random ready bursts, one long hold-off on request, and always
  // ready once the run goes quiet.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk_i);
      end
    end
  end

  // Main stimulus
  initial begin
    logic [2:0] phase_model [RandPhases];
    phase_model = '{MdlDefault, MdlArtWide, MdlSmallPad, MdlArtIv,
                    MdlPenPal, MdlSpareLo, MdlDefault, MdlArtWide};

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // --- directed: default layout, slider state starts at -5 ---
    set_model(MdlDefault);
    // left slider at 0 is too far from -5 but still moves the state;
    // right slider at 2 then reports +2
    send_report(KindButtons, MarkLeft, 8'h00, MarkRight, 8'h02,
                8'h00, 8'h00, 8'h00, 8'h00);
    // zero delta on the left, key nibble on the right
    send_report(KindButtons, MarkLeft, 8'h02, MarkRight, 8'ha6,
                8'h00, 8'h00, 8'h00, 8'h00);
    // key nibble on the left, out-of-range slider byte on the right
    send_report(KindButtons, MarkLeft, 8'ha8, MarkRight, 8'h40,
                8'hff, 8'hff, 8'hff, 8'hff);
    // big jump to the top position: not reported, state still replaced
    send_report(KindButtons, MarkLeft, SliderMax, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h00);
    // -3 then +3, summed to zero but reported
    send_report(KindButtons, MarkLeft, 8'h3c, MarkRight, SliderMax,
                8'h00, 8'h00, 8'h00, 8'h00);
    // pen with everything at its maximum: positions saturate
    send_report(KindPen, 8'hff, 8'hff, 8'hff, 8'hff,
                8'hff, 8'hff, 8'hff, 8'hff);
    // pen out of range (keys only), then just in range at position zero
    send_report(KindPen, 8'h0f, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h00);
    send_report(KindPen, 8'h10, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h00);
    // unknown kind: all-zero result
    send_report(KindUnknown, 8'hff, 8'hff, 8'hff, 8'hff,
                8'hff, 8'hff, 8'hff, 8'hff);

    // --- small pad: left key from pressure threshold ---
    set_model(MdlSmallPad);
    send_report(KindPen, 8'hf3, 8'h12, 8'h34, 8'h0e, 8'h7f, PressKeyThr, 8'hc5, 8'h80);
    send_report(KindPen, 8'h20, 8'h27, 8'hde, 8'h1c, 8'hfe, PressKeyThr + 8'd1,
                8'h3f, 8'h01);
    send_report(KindButtons, MarkLeft, 8'h01, MarkRight, SliderMax,
                8'h00, 8'h00, 8'h00, 8'h00);

    // --- pen pal ---
    set_model(MdlPenPal);
    send_report(KindPen, 8'he7, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_report(KindPen, 8'hc7, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_report(KindPen, 8'he0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_report(KindPadKeys, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_report(KindButtons, MarkLeft, 8'h01, MarkRight, 8'h01,
                8'h00, 8'h00, 8'h00, 8'h00);

    // --- large tablet, little-endian button reports ---
    set_model(MdlArtIv);
    send_report(KindButtons, 8'h0f, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_report(KindPen, 8'h01, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_report(KindPen, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_report(KindPadKeys, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

    // --- wide variant: raw little-endian pressure ---
    set_model(MdlArtWide);
    send_report(KindButtons, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_report(KindPen, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_report(KindPadKeys, 8'h00, 8'h00, 8'haa, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

    // --- undefined model code falls back to default ---
    set_model(MdlSpareHi);
    send_report(KindPen, 8'hf0, 8'h13, 8'hef, 8'h0a, 8'h55, 8'h9c, 8'h41, 8'h7e);

    // --- random phases, one model each ---
    for (int p = 0; p < RandPhases; p++) begin
      set_model(phase_model[p]);
      if (p == RandPhases - 1) quiet = 1'b1;
      for (int n = 0; n < PhaseItems; n++) begin
        // long receiver hold-off while reports keep coming
        if (p == 2 && n == 5) hold_req = 1'b1;
        // sender waits for every result before going on
        if (p == 4 && n == PhaseItems / 2) begin
          idle_sender(1);
          wait_drained();
        end
        if (!quiet && $urandom_range(0, 7) == 0) idle_sender($urandom_range(1, 16));
        send_random();
      end
    end

    idle_sender(1);
    wait_drained();
    repeat (10) @(negedge clk_i);

    $display("Covered %0d reports over %0d model settings, all layouts and the fallback,",
             reports_sent, models_set);
    $display("with slider tracking, saturation, unknown kinds and stalls on both channels.");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", pending_count);
    $display("== FAIL ==");
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/trd_pkg.sv
hw/rtl/trd_front.sv
hw/rtl/trd_queue.sv
hw/rtl/trd_back.sv
hw/rtl/tablet_report_decoder_core.sv
hw/rtl/trd_checker.sv
tb/sv/trd_checker.sv
tb/sv/tb_top.sv
